>>> design/patxq_pkg.sv
// Shared types, widths and constants for the priority admission transmit queue.
package patxq_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
   localparam int USED_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int HANDLE_W = 32;
   localparam int LENGTH_W = 16;
   localparam int PRIO_W   = 2;
   localparam int MEM_W    = 18;
   localparam int SLOTS_W  = 6;
   localparam int OCC_W    = 6;
   localparam int DROP_W   = 32;

   localparam int CMP_W     = (USED_W > SLOTS_W) ? USED_W : SLOTS_W;
   localparam int OCC_EXT_W = (USED_W > OCC_W) ? USED_W : OCC_W;

   localparam int REQ_FIELDS_W = HANDLE_W + LENGTH_W + PRIO_W + MEM_W + 2;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 4 + HANDLE_W + LENGTH_W + OCC_W + DROP_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = MEM_W;

   localparam logic [MEM_W-1:0]   LOW_MEM_MIN_RST    = MEM_W'(20000);
   localparam logic [MEM_W-1:0]   MED_MEM_MIN_RST    = MEM_W'(10000);
   localparam logic [MEM_W-1:0]   HIGH_MEM_MIN_RST   = MEM_W'(2000);
   localparam logic [SLOTS_W-1:0] LOW_SLOTS_MIN_RST  = SLOTS_W'(15);
   localparam logic [SLOTS_W-1:0] MED_SLOTS_MIN_RST  = SLOTS_W'(10);
   localparam logic [SLOTS_W-1:0] HIGH_SLOTS_MIN_RST = SLOTS_W'(1);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LOW_MEM_MIN    = 3'd0,
      CSR_MED_MEM_MIN    = 3'd1,
      CSR_HIGH_MEM_MIN   = 3'd2,
      CSR_LOW_SLOTS_MIN  = 3'd3,
      CSR_MED_SLOTS_MIN  = 3'd4,
      CSR_HIGH_SLOTS_MIN = 3'd5
   } csr_index_type;

   typedef enum logic {
      FUNC_PUSH = 1'b0,
      FUNC_SEND = 1'b1
   } func_type;

   typedef enum logic [PRIO_W-1:0] {
      PRIO_LOW  = 2'd0,
      PRIO_MED  = 2'd1,
      PRIO_HIGH = 2'd2,
      PRIO_ANY  = 2'd3
   } prio_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   typedef struct packed {
      logic load;   // capture the request transfer
      logic exec;   // apply the item to queue state and build the result
   } cmd_type;

endpackage

>>> design/patxq_ctrl.sv
// Sequencing state machine: capture, execute, then hold the result for transfer.
module patxq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output patxq_pkg::cmd_type cmd
);
   import patxq_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      state_in   = state_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            rsp_tvalid = 1'b1;
            // take the next request in the cycle the result leaves
            req_tready = rsp_tready;
            if (rsp_tready) state_in = req_tvalid ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign cmd.load = req_tvalid & req_tready;
   assign cmd.exec = (state_ff == ST_EXEC);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

>>> design/patxq_dpath.sv
// Queue storage, pointers, admission checks, drop counter and result register.
module patxq_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  patxq_pkg::cmd_type                   cmd,
   input  logic [patxq_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                 req_tuser,
   output logic [patxq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_we,
   input  logic [patxq_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [patxq_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import patxq_pkg::*;

   // configuration
   logic [MEM_W-1:0]   low_mem_min_ff, med_mem_min_ff, high_mem_min_ff;
   logic [SLOTS_W-1:0] low_slots_min_ff, med_slots_min_ff, high_slots_min_ff;

   // captured item
   logic                func_ff;
   logic [HANDLE_W-1:0] handle_ff;
   logic [LENGTH_W-1:0] length_ff;
   logic [PRIO_W-1:0]   prio_ff;
   logic [MEM_W-1:0]    mem_free_ff;
   logic                alloc_ok_ff;
   logic                sink_ready_ff;

   // queue state
   logic [HANDLE_W-1:0] handle_mem [QUEUE_DEPTH];
   logic [LENGTH_W-1:0] length_mem [QUEUE_DEPTH];
   logic [ADDR_W-1:0]   wr_slot_ff, wr_slot_in, rd_slot_ff, rd_slot_in;
   logic                wr_phase_ff, wr_phase_in, rd_phase_ff, rd_phase_in;
   logic                wake_pending_ff, wake_pending_in;
   logic [DROP_W-1:0]   drop_count_ff, drop_count_in;

   // result
   logic                accepted_ff, accepted_in;
   logic                dropped_ff, dropped_in;
   logic                wake_ff, wake_in;
   logic                out_valid_ff;
   logic [HANDLE_W-1:0] out_handle_ff;
   logic [LENGTH_W-1:0] out_length_ff;
   logic [OCC_W-1:0]    occupancy_ff, occupancy_in;

   logic [USED_W-1:0]    wr_ext, rd_ext, used, free_slots, used_next;
   logic                 full, empty, reject, do_push, do_pop;
   logic [MEM_W-1:0]     mem_min;
   logic [SLOTS_W-1:0]   slots_min;
   logic                 prio_checked;
   logic [OCC_EXT_W-1:0] used_next_ext;

   assign wr_ext = USED_W'(wr_slot_ff);
   assign rd_ext = USED_W'(rd_slot_ff);
   assign used   = (wr_phase_ff == rd_phase_ff) ? (wr_ext - rd_ext)
                                                : (USED_W'(QUEUE_DEPTH) + wr_ext - rd_ext);
   assign full       = (used == USED_W'(QUEUE_DEPTH));
   assign empty      = (used == '0);
   assign free_slots = USED_W'(QUEUE_DEPTH) - used;

   always_comb begin
      mem_min      = low_mem_min_ff;
      slots_min    = low_slots_min_ff;
      prio_checked = 1'b1;
      case (prio_type'(prio_ff))
         PRIO_LOW: begin
            mem_min   = low_mem_min_ff;
            slots_min = low_slots_min_ff;
         end
         PRIO_MED: begin
            mem_min   = med_mem_min_ff;
            slots_min = med_slots_min_ff;
         end
         PRIO_HIGH: begin
            mem_min   = high_mem_min_ff;
            slots_min = high_slots_min_ff;
         end
         default: begin
            prio_checked = 1'b0;
         end
      endcase
   end

   assign reject = full | (prio_checked & ((mem_free_ff < mem_min) |
                           (CMP_W'(free_slots) < CMP_W'(slots_min))));

   assign do_push = (func_ff == FUNC_PUSH) & ~reject & alloc_ok_ff;
   assign do_pop  = (func_ff == FUNC_SEND) & sink_ready_ff & ~empty;

   always_comb begin
      wr_slot_in      = wr_slot_ff;
      wr_phase_in     = wr_phase_ff;
      rd_slot_in      = rd_slot_ff;
      rd_phase_in     = rd_phase_ff;
      wake_pending_in = wake_pending_ff;
      drop_count_in   = drop_count_ff;
      accepted_in     = 1'b0;
      dropped_in      = 1'b0;
      wake_in         = 1'b0;
      used_next       = used;
      if (func_ff == FUNC_PUSH) begin
         if (reject) begin
            drop_count_in = drop_count_ff + 1'b1;
            dropped_in    = 1'b1;
         end else if (alloc_ok_ff) begin
            accepted_in = 1'b1;
            used_next   = used + 1'b1;
            if (wr_slot_ff == ADDR_W'(QUEUE_DEPTH - 1)) begin
               wr_slot_in  = '0;
               wr_phase_in = ~wr_phase_ff;
            end else begin
               wr_slot_in = wr_slot_ff + 1'b1;
            end
            if (!wake_pending_ff) begin
               wake_pending_in = 1'b1;
               wake_in         = 1'b1;
            end
         end
      end else begin
         wake_pending_in = 1'b0;
         if (do_pop) begin
            used_next = used - 1'b1;
            if (rd_slot_ff == ADDR_W'(QUEUE_DEPTH - 1)) begin
               rd_slot_in  = '0;
               rd_phase_in = ~rd_phase_ff;
            end else begin
               rd_slot_in = rd_slot_ff + 1'b1;
            end
         end
      end
   end

   assign used_next_ext = OCC_EXT_W'(used_next);
   assign occupancy_in  = used_next_ext[OCC_W-1:0];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         low_mem_min_ff    <= LOW_MEM_MIN_RST;
         med_mem_min_ff    <= MED_MEM_MIN_RST;
         high_mem_min_ff   <= HIGH_MEM_MIN_RST;
         low_slots_min_ff  <= LOW_SLOTS_MIN_RST;
         med_slots_min_ff  <= MED_SLOTS_MIN_RST;
         high_slots_min_ff <= HIGH_SLOTS_MIN_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_LOW_MEM_MIN:    low_mem_min_ff    <= csr_wdata;
            CSR_MED_MEM_MIN:    med_mem_min_ff    <= csr_wdata;
            CSR_HIGH_MEM_MIN:   high_mem_min_ff   <= csr_wdata;
            CSR_LOW_SLOTS_MIN:  low_slots_min_ff  <= csr_wdata[SLOTS_W-1:0];
            CSR_MED_SLOTS_MIN:  med_slots_min_ff  <= csr_wdata[SLOTS_W-1:0];
            CSR_HIGH_SLOTS_MIN: high_slots_min_ff <= csr_wdata[SLOTS_W-1:0];
            default: ;
         endcase
      end
   end

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff       <= req_tuser;
         handle_ff     <= req_tdata[HANDLE_W-1:0];
         length_ff     <= req_tdata[HANDLE_W +: LENGTH_W];
         prio_ff       <= req_tdata[HANDLE_W + LENGTH_W +: PRIO_W];
         mem_free_ff   <= req_tdata[HANDLE_W + LENGTH_W + PRIO_W +: MEM_W];
         alloc_ok_ff   <= req_tdata[HANDLE_W + LENGTH_W + PRIO_W + MEM_W];
         sink_ready_ff <= req_tdata[HANDLE_W + LENGTH_W + PRIO_W + MEM_W + 1];
      end
   end

   // queue control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_slot_ff      <= '0;
         wr_phase_ff     <= 1'b0;
         rd_slot_ff      <= '0;
         rd_phase_ff     <= 1'b0;
         wake_pending_ff <= 1'b0;
         drop_count_ff   <= '0;
      end else if (cmd.exec) begin
         wr_slot_ff      <= wr_slot_in;
         wr_phase_ff     <= wr_phase_in;
         rd_slot_ff      <= rd_slot_in;
         rd_phase_ff     <= rd_phase_in;
         wake_pending_ff <= wake_pending_in;
         drop_count_ff   <= drop_count_in;
      end
   end

   // storage write and registered read; push and pop never share a cycle
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (do_push) begin
            handle_mem[wr_slot_ff] <= handle_ff;
            length_mem[wr_slot_ff] <= length_ff;
         end
         if (do_pop) begin
            out_handle_ff <= handle_mem[rd_slot_ff];
            out_length_ff <= length_mem[rd_slot_ff];
         end else begin
            out_handle_ff <= '0;
            out_length_ff <= '0;
         end
         out_valid_ff <= do_pop;
         accepted_ff  <= accepted_in;
         dropped_ff   <= dropped_in;
         wake_ff      <= wake_in;
         occupancy_ff <= occupancy_in;
      end
   end

   assign rsp_tdata = RSP_DATA_W'({drop_count_ff, occupancy_ff, out_length_ff, out_handle_ff,
                                   out_valid_ff, wake_ff, dropped_ff, accepted_ff});

endmodule

>>> design/priority_admission_tx_queue.sv
// Top level of the transmit descriptor queue with priority watermark admission.
//
//   channel   direction  payload
//   req_*     in         tuser: func; tdata: pkt_handle, pkt_length, priority_req,
//                        mem_free, alloc_ok, sink_ready
//   rsp_*     out        tdata: accepted, dropped, wake_request, out_valid, out_handle,
//                        out_length, occupancy, drop_total
//   csr_*     in         write enable, register index, write data
//
// A request transfer moves the controller to ST_EXEC, which updates pointers and counters
// and reads the storage RAM into the result register; ST_DONE then holds the result valid.
// A new request transfers in the same cycle as the pending result, so the block takes no
// new item until the result of the last one has been taken.
// Synchronous active-high reset clears pointers, wake flag and drop counter and loads the
// default thresholds; storage contents are not cleared.
module priority_admission_tx_queue (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // bit 0: func
   input  logic                                 req_tuser,
   // [31:0] pkt_handle, [47:32] pkt_length, [49:48] priority_req, [67:50] mem_free,
   // [68] alloc_ok, [69] sink_ready, rest zero
   input  logic [patxq_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] accepted, [1] dropped, [2] wake_request, [3] out_valid, [35:4] out_handle,
   // [51:36] out_length, [57:52] occupancy, [89:58] drop_total, rest zero
   output logic [patxq_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                 csr_we,
   input  logic [patxq_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [patxq_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import patxq_pkg::*;

   cmd_type cmd;

   patxq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   patxq_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

endmodule

>>> sim/tb.sv
// Testbench for the priority admission transmit queue: directed and random traffic against a predictor.
`timescale 1ns / 100ps

module tb;
   import patxq_pkg::*;

   localparam int MEM_MAX      = (1 << MEM_W) - 1;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 235;
   localparam int HOLD_CYCLES  = 150;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      func_type            func;
      logic                ready;
      logic                alloc;
      logic [MEM_W-1:0]    mem;
      prio_type            prio;
      logic [LENGTH_W-1:0] length;
      logic [HANDLE_W-1:0] handle;
   } desc_req_type;

   typedef struct packed {
      logic                accepted;
      logic                dropped;
      logic                wake;
      logic                popped;
      logic [HANDLE_W-1:0] handle;
      logic [LENGTH_W-1:0] length;
      logic [OCC_W-1:0]    occupancy;
      logic [DROP_W-1:0]   drops;
   } queue_outcome_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   priority_admission_tx_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // predictor state: queue contents, wake flag, drop counter, thresholds
   logic [HANDLE_W-1:0] stored_handles[$];
   logic [LENGTH_W-1:0] stored_lengths[$];
   logic                wake_held = 1'b0;
   logic [DROP_W-1:0]   drop_tally = '0;
   logic [MEM_W-1:0]    mem_floor [0:2];
   logic [SLOTS_W-1:0]  slot_floor [0:2];

   desc_req_type      pending_requests[$];
   queue_outcome_type expected_outcomes[$];

   bit req_taken = 1'b0;
   bit steady = 1'b0;
   int hold_requests = 0;
   int holds_served = 0;
   int hold_left = 0;
   int cycle_count = 0;
   int mismatch_count = 0;
   int requests_sent = 0;
   int results_checked = 0;
   int admitted = 0;
   int full_drops = 0;
   int silent_discards = 0;
   int dequeued = 0;
   int idle_sends = 0;

   initial begin
      mem_floor[PRIO_LOW]   = LOW_MEM_MIN_RST;
      mem_floor[PRIO_MED]   = MED_MEM_MIN_RST;
      mem_floor[PRIO_HIGH]  = HIGH_MEM_MIN_RST;
      slot_floor[PRIO_LOW]  = LOW_SLOTS_MIN_RST;
      slot_floor[PRIO_MED]  = MED_SLOTS_MIN_RST;
      slot_floor[PRIO_HIGH] = HIGH_SLOTS_MIN_RST;
   end

   // Apply one item to the predicted queue and return the result it must produce.
   function automatic queue_outcome_type admit_or_send(desc_req_type r);
      queue_outcome_type o;
      int                used;
      int                free_slots;
      logic              reject;
      o = '0;
      used = stored_handles.size();
      if (r.func == FUNC_PUSH) begin
         reject = 1'b0;
         if (used >= QUEUE_DEPTH) begin
            reject = 1'b1;
            full_drops++;
         end else if (r.prio != PRIO_ANY) begin
            free_slots = QUEUE_DEPTH - used;
            reject = (r.mem < mem_floor[int'(r.prio)]) ||
                     (free_slots < int'(slot_floor[int'(r.prio)]));
         end
         if (reject) begin
            drop_tally = drop_tally + 1'b1;
            o.dropped = 1'b1;
         end else if (r.alloc) begin
            stored_handles.push_back(r.handle);
            stored_lengths.push_back(r.length);
            o.accepted = 1'b1;
            admitted++;
            if (!wake_held) begin
               wake_held = 1'b1;
               o.wake = 1'b1;
            end
         end else begin
            silent_discards++;
         end
      end else begin
         wake_held = 1'b0;
         if (r.ready && used != 0) begin
            o.popped = 1'b1;
            o.handle = stored_handles.pop_front();
            o.length = stored_lengths.pop_front();
            dequeued++;
         end else begin
            idle_sends++;
         end
      end
      o.occupancy = OCC_W'(stored_handles.size());
      o.drops = drop_tally;
      return o;
   endfunction

   function automatic desc_req_type make_request(func_type f, logic [HANDLE_W-1:0] h,
                                                 int l, prio_type p,
                                                 int m, int a, int rdy);
      desc_req_type r;
      r.func = f;
      r.handle = h;
      r.length = LENGTH_W'(l);
      r.prio = p;
      r.mem = MEM_W'(m);
      r.alloc = a[0];
      r.ready = rdy[0];
      return r;
   endfunction

   // Well-formed items aim mem_free at the threshold of their priority; noise is uniform.
   function automatic desc_req_type random_request(int push_pct, bit noise);
      desc_req_type r;
      int           level;
      int           pick;
      r.handle = $urandom;
      r.length = LENGTH_W'($urandom);
      r.prio = prio_type'($urandom_range(3));
      r.func = ($urandom_range(99) < push_pct) ? FUNC_PUSH : FUNC_SEND;
      if (noise) begin
         r.func = func_type'($urandom_range(1));
         r.mem = MEM_W'($urandom);
         r.alloc = 1'($urandom_range(1));
         r.ready = 1'($urandom_range(1));
         return r;
      end
      r.alloc = $urandom_range(99) < 92;
      r.ready = $urandom_range(99) < 85;
      level = (r.prio == PRIO_ANY) ? int'($urandom_range(MEM_MAX))
                                   : int'(mem_floor[int'(r.prio)]);
      pick = $urandom_range(99);
      if (pick < 35)
         level = level + int'($urandom_range(4)) - 2;
      else if (pick < 60)
         level = $urandom_range(MEM_MAX, level);
      else if (pick < 75)
         level = $urandom_range(MEM_MAX);
      else if (pick < 85)
         level = $urandom_range(1) ? MEM_MAX : 0;
      else
         level = $urandom_range(level);
      if (level < 0) level = 0;
      if (level > MEM_MAX) level = MEM_MAX;
      r.mem = MEM_W'(level);
      return r;
   endfunction

   // Queue bursts that fill, drain or churn the queue; a tenth of the items are noise.
   task automatic queue_random_items(int count);
      int burst;
      int push_pct;
      int mode;
      while (count > 0) begin
         burst = $urandom_range(48, 8);
         mode = $urandom_range(2);
         push_pct = (mode == 0) ? 85 : (mode == 1) ? 25 : 55;
         for (int i = 0; i < burst && count > 0; i++) begin
            pending_requests.push_back(random_request(push_pct, $urandom_range(9) == 0));
            count--;
         end
      end
   endtask

   task automatic program_thresholds(logic [MEM_W-1:0] low_m, logic [MEM_W-1:0] med_m,
                                     logic [MEM_W-1:0] high_m, logic [SLOTS_W-1:0] low_s,
                                     logic [SLOTS_W-1:0] med_s, logic [SLOTS_W-1:0] high_s);
      csr_index_type          idx;
      logic [CSR_DATA_W-1:0]  value;
      for (int i = CSR_LOW_MEM_MIN; i <= CSR_HIGH_SLOTS_MIN; i++) begin
         idx = csr_index_type'(i);
         case (idx)
            CSR_LOW_MEM_MIN: begin
               value = low_m;
               mem_floor[PRIO_LOW] = low_m;
            end
            CSR_MED_MEM_MIN: begin
               value = med_m;
               mem_floor[PRIO_MED] = med_m;
            end
            CSR_HIGH_MEM_MIN: begin
               value = high_m;
               mem_floor[PRIO_HIGH] = high_m;
            end
            CSR_LOW_SLOTS_MIN: begin
               value = CSR_DATA_W'(low_s);
               slot_floor[PRIO_LOW] = low_s;
            end
            CSR_MED_SLOTS_MIN: begin
               value = CSR_DATA_W'(med_s);
               slot_floor[PRIO_MED] = med_s;
            end
            default: begin
               value = CSR_DATA_W'(high_s);
               slot_floor[PRIO_HIGH] = high_s;
            end
         endcase
         @(negedge clock);
         csr_we <= 1'b1;
         csr_addr <= idx;
         csr_wdata <= value;
      end
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_until_drained();
      @(posedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // sender: hold the item until its transfer, then idle or present the next one
   always @(negedge clock) begin
      desc_req_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 29)) begin
            r = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= r.func;
            req_tdata <= REQ_DATA_W'({r.ready, r.alloc, r.mem, r.prio, r.length, r.handle});
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_left == 0 && holds_served != hold_requests) begin
         holds_served++;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || $urandom_range(99) >= 29;
      end
   end

   always @(posedge clock) begin
      desc_req_type      r;
      queue_outcome_type got;
      queue_outcome_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            r.func = func_type'(req_tuser);
            r.handle = req_tdata[31:0];
            r.length = req_tdata[47:32];
            r.prio = prio_type'(req_tdata[49:48]);
            r.mem = req_tdata[67:50];
            r.alloc = req_tdata[68];
            r.ready = req_tdata[69];
            expected_outcomes.push_back(admit_or_send(r));
            requests_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.accepted = rsp_tdata[0];
            got.dropped = rsp_tdata[1];
            got.wake = rsp_tdata[2];
            got.popped = rsp_tdata[3];
            got.handle = rsp_tdata[35:4];
            got.length = rsp_tdata[51:36];
            got.occupancy = rsp_tdata[57:52];
            got.drops = rsp_tdata[89:58];
            if (expected_outcomes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("%0t: result transfer with nothing outstanding: %h", $realtime,
                           rsp_tdata);
            end else begin
               want = expected_outcomes.pop_front();
               results_checked++;
               if (got.accepted !== want.accepted || got.dropped !== want.dropped ||
                   got.wake !== want.wake || got.popped !== want.popped ||
                   got.handle !== want.handle || got.length !== want.length ||
                   got.occupancy !== want.occupancy || got.drops !== want.drops) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT) begin
                     $display("%0t: mismatch on result %0d", $realtime, results_checked);
                     $display("  exp acc=%b drp=%b wake=%b pop=%b h=%h len=%h occ=%0d drops=%0d",
                              want.accepted, want.dropped, want.wake, want.popped,
                              want.handle, want.length, want.occupancy, want.drops);
                     $display("  got acc=%b drp=%b wake=%b pop=%b h=%h len=%h occ=%0d drops=%0d",
                              got.accepted, got.dropped, got.wake, got.popped,
                              got.handle, got.length, got.occupancy, got.drops);
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_outcomes.size());
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      logic [MEM_W-1:0]   m_low, m_med, m_high;
      logic [SLOTS_W-1:0] s_low, s_med, s_high;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset thresholds: low 20000/15, medium 10000/10, high 2000/1
      pending_requests.push_back(make_request(FUNC_SEND, '1, '1, PRIO_ANY, MEM_MAX, 1, 1));
      pending_requests.push_back(make_request(FUNC_SEND, 0, 0, PRIO_LOW, 0, 0, 0));
      pending_requests.push_back(make_request(FUNC_PUSH, 32'h1234_5678, 'h0040,
                                              PRIO_ANY, 0, 0, 1));
      pending_requests.push_back(make_request(FUNC_PUSH, 1, 1, PRIO_LOW, 19999, 1, 0));
      pending_requests.push_back(make_request(FUNC_PUSH, 0, 0, PRIO_LOW, 20000, 1, 0));
      pending_requests.push_back(make_request(FUNC_PUSH, 2, 2, PRIO_MED, 9999, 1, 1));
      pending_requests.push_back(make_request(FUNC_PUSH, '1, '1, PRIO_MED, 10000, 1, 1));
      pending_requests.push_back(make_request(FUNC_PUSH, 3, 3, PRIO_HIGH, 1999, 0, 0));
      pending_requests.push_back(make_request(FUNC_PUSH, 32'hA5A5_5A5A, 'h5AA5,
                                              PRIO_HIGH, MEM_MAX, 1, 0));
      pending_requests.push_back(make_request(FUNC_SEND, 0, 0, PRIO_ANY, 0, 1, 0));
      pending_requests.push_back(make_request(FUNC_PUSH, 32'h8000_0001, 'h8001,
                                              PRIO_ANY, 0, 1, 0));
      pending_requests.push_back(make_request(FUNC_SEND, 0, 0, PRIO_LOW, 0, 0, 1));
      pending_requests.push_back(make_request(FUNC_SEND, '1, '1, PRIO_HIGH, MEM_MAX, 1, 1));
      pending_requests.push_back(make_request(FUNC_PUSH, 32'h0F0F_F0F0, 'hF00F,
                                              PRIO_LOW, MEM_MAX, 1, 1));
      pending_requests.push_back(make_request(FUNC_PUSH, 5, 5, PRIO_HIGH, 2000, 0, 1));
      pending_requests.push_back(make_request(FUNC_SEND, 0, 0, PRIO_MED, 0, 0, 1));
      pending_requests.push_back(make_request(FUNC_SEND, 0, 0, PRIO_MED, 0, 0, 1));
      pending_requests.push_back(make_request(FUNC_SEND, 0, 0, PRIO_MED, 0, 0, 1));
      pending_requests.push_back(make_request(FUNC_SEND, 0, 0, PRIO_MED, 0, 0, 1));
      wait_until_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               m_low = '0; m_med = '0; m_high = '0;
               s_low = '0; s_med = '0; s_high = '0;
            end
            1: begin
               m_low = MEM_W'(MEM_MAX); m_med = MEM_W'(MEM_MAX); m_high = MEM_W'(MEM_MAX);
               s_low = SLOTS_W'(QUEUE_DEPTH); s_med = SLOTS_W'(QUEUE_DEPTH);
               s_high = SLOTS_W'(QUEUE_DEPTH);
            end
            2: begin
               m_low = LOW_MEM_MIN_RST; m_med = MED_MEM_MIN_RST; m_high = HIGH_MEM_MIN_RST;
               s_low = LOW_SLOTS_MIN_RST; s_med = MED_SLOTS_MIN_RST;
               s_high = HIGH_SLOTS_MIN_RST;
            end
            default: begin
               m_low = ($urandom_range(5) == 0) ? MEM_W'($urandom)
                                                : MEM_W'($urandom_range(40000));
               m_med = MEM_W'($urandom_range(40000));
               m_high = MEM_W'($urandom_range(20000));
               s_low = SLOTS_W'($urandom_range(QUEUE_DEPTH));
               s_med = SLOTS_W'($urandom_range(QUEUE_DEPTH));
               s_high = SLOTS_W'($urandom_range(QUEUE_DEPTH));
            end
         endcase
         program_thresholds(m_low, m_med, m_high, s_low, s_med, s_high);
         steady = (phase == 3);
         queue_random_items(PHASE_ITEMS);
         // let the sender keep offering while the result side stalls
         if (phase == 5) hold_requests++;
         wait_until_drained();
      end
      steady = 1'b0;
      repeat (10) @(posedge clock);

      $display("Covered %0d requests under %0d threshold settings: %0d admitted, %0d dropped",
               requests_sent, PHASES + 1, admitted, drop_tally);
      $display("(%0d at a full queue), %0d discarded, %0d dequeued, %0d sends without a pop",
               full_drops, silent_discards, dequeued, idle_sends);
      if (expected_outcomes.size() != 0)
         $display("%0d expected results never arrived", expected_outcomes.size());
      if (mismatch_count == 0 && expected_outcomes.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/patxq_pkg.sv
design/patxq_ctrl.sv
design/patxq_dpath.sv
design/priority_admission_tx_queue.sv
sim/tb.sv
